// ===== sv/rpn_calc_pkg.sv =====
package rpn_calc_pkg;

	// Stack and number format
	localparam int STACK_DEPTH = 16;
	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int NUM_W       = 16;
	localparam int FUNC_W      = 3;
	localparam int STAT_W      = 3;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// Divider sizing: dividend is |a| scaled by the fraction bits
	localparam int DV_W    = DATA_W + FRAC_BITS;
	localparam int DIV_QB  = (DV_W > DATA_W + 1) ? DATA_W + 1 : DV_W;
	localparam int DIV_CW  = $clog2(DIV_QB + 1);

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic signed [DATA_W-1:0] word_t;

	// Token kinds
	localparam func_t FN_NUM = 3'd0;
	localparam func_t FN_ADD = 3'd1;
	localparam func_t FN_SUB = 3'd2;
	localparam func_t FN_MUL = 3'd3;
	localparam func_t FN_DIV = 3'd4;
	localparam func_t FN_FIN = 3'd5;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 3'd0,
		ST_UNDER = 3'd1,
		ST_OVER  = 3'd2,
		ST_DIV0  = 3'd3,
		ST_LEFT  = 3'd4
	} status_t;

	localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Clamp a 64-bit signed value to the word range
	function automatic word_t sat_word(input logic signed [63:0] v);
		word_t r;
		if (v > 64'(WORD_MAX))
			r = WORD_MAX;
		else if (v < 64'(WORD_MIN))
			r = WORD_MIN;
		else
			r = v[DATA_W-1:0];
		return r;
	endfunction

endpackage

// ===== sv/rpn_in_if.sv =====
interface rpn_in_if import rpn_calc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	func_t                   func;
	logic signed [NUM_W-1:0] number_value;

	modport source(output valid, func, number_value, input ready);
	modport sink(input valid, func, number_value, output ready);
endinterface

// ===== sv/rpn_out_if.sv =====
interface rpn_out_if import rpn_calc_pkg::*; ();
	logic              valid;
	logic              ready;
	word_t             top_value;
	logic [STAT_W-1:0] status;
	logic              expression_done;

	modport source(output valid, top_value, status, expression_done, input ready);
	modport sink(input valid, top_value, status, expression_done, output ready);
endinterface

// ===== sv/rpn_calc_div.sv =====
module rpn_calc_div import rpn_calc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DV_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	input  logic            neg,
	output logic            done,
	output word_t           quot
);

	localparam logic [DATA_W+1:0] MAG_POS = (DATA_W+2)'(WORD_MAX);
	localparam logic [DATA_W+1:0] MAG_NEG = MAG_POS + (DATA_W+2)'(1);

	logic              busy_q;
	logic              ovf_q;
	logic              neg_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dsr_q;
	logic [DIV_QB-1:0] dvd_q;
	logic [DIV_QB-1:0] quo_q;
	word_t             quot_q;

	logic [DV_W-1:0]   hi_part;
	logic              hi_ovf;
	logic [DATA_W:0]   trial;
	logic              fit;
	logic [DATA_W+1:0] mag;
	word_t             sat_res;

	// Quotient would not fit in DIV_QB bits when the upper part alone reaches the divisor
	assign hi_part = dividend >> DIV_QB;
	assign hi_ovf  = hi_part >= DV_W'(divisor);

	// One restoring step per cycle
	assign trial = {rem_q, dvd_q[DIV_QB-1]};
	assign fit   = trial >= {1'b0, dsr_q};

	// Apply sign and clamp
	always_comb begin
		mag = (DATA_W+2)'(quo_q);
		if (neg_q) begin
			if (ovf_q || mag > MAG_NEG)
				sat_res = WORD_MIN;
			else
				sat_res = word_t'(-mag);
		end else begin
			if (ovf_q || mag > MAG_POS)
				sat_res = WORD_MAX;
			else
				sat_res = mag[DATA_W-1:0];
		end
	end

	// Iterate one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				ovf_q  <= hi_ovf;
				neg_q  <= neg;
				cnt_q  <= DIV_CW'(DIV_QB);
				rem_q  <= hi_part[DATA_W-1:0];
				dsr_q  <= divisor;
				dvd_q  <= dividend[DIV_QB-1:0];
				quo_q  <= '0;
			end else if (busy_q) begin
				if (ovf_q || cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					quot_q <= sat_res;
				end else begin
					done_q <= 1'b0;
					cnt_q  <= cnt_q - DIV_CW'(1);
					dvd_q  <= dvd_q << 1;
					quo_q  <= {quo_q[DIV_QB-2:0], fit};
					if (fit)
						rem_q <= DATA_W'(trial - {1'b0, dsr_q});
					else
						rem_q <= trial[DATA_W-1:0];
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== sv/rpn_stack_calculator_unit.sv =====
// Postfix expression evaluator on a Q16.16 operand stack.
// The tokens channel takes one word per token: func (number, add, sub, mul,
// div, finish) and number_value. The results channel returns exactly one word
// per token: top_value, status and expression_done. Both are valid/ready
// handshakes; a word moves when valid and ready are high at a clock edge.
// One token is worked at a time; tokens.ready is high while the block is idle.
// A number, finish, spare code or operator with too few operands goes from
// acceptance straight to the emit state; add and sub first read the second
// operand and write back, mul adds a product register, and div waits on
// the radix-2 divider (one quotient bit per cycle, 33 bits; a zero divisor
// skips it, an out-of-range quotient ends it early). The next token can be
// taken in the cycle after the result register loads. The stack lives in a
// one-port-write, one-port-read memory with a registered read; the top entry
// is also held in a register, so only operators read the memory.
// The result register lets the next token be accepted while a result waits.
// When the receiver stalls, a second finished result is held inside the block
// and no further token is taken until the result register frees up.
// Reset clears the stack count and error status; the memory is not cleared,
// since no entry is read before it is written.
module rpn_stack_calculator_unit import rpn_calc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	rpn_in_if.sink   tokens,
	rpn_out_if.source results
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MUL,
		S_DIV,
		S_WB,
		S_EMIT
	} state_t;

	state_t            state_q;
	func_t             func_q;
	logic [CNT_W-1:0]  count_q;
	status_t           err_q;
	word_t             top_q;
	word_t             res_val_q;
	logic signed [63:0] prod_q;
	word_t             res_top_q;
	status_t           res_status_q;
	logic              res_done_q;
	logic              out_valid_q;
	word_t             out_top_q;
	logic [STAT_W-1:0] out_status_q;
	logic              out_done_q;

	word_t             stack_mem [STACK_DEPTH];
	word_t             rd_q;

	logic              accept;
	logic [CNT_W-1:0]  cnt_m2;
	logic [CNT_W-1:0]  cnt_p1;
	logic              full;
	logic              two_up;
	word_t             num_fx;
	word_t             top_shown;
	word_t             add_res;
	word_t             sub_res;
	word_t             mul_res;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	word_t             mem_wdata;
	logic              mem_re;
	logic [DATA_W-1:0] abs_a;
	logic [DATA_W-1:0] abs_b;
	logic              div_start;
	logic              div_done;
	word_t             div_quot;

	function automatic status_t flag_err(input status_t cur, input status_t code);
		return (cur == ST_OK) ? code : cur;
	endfunction

	assign tokens.ready = (state_q == S_IDLE);
	assign accept       = tokens.valid && tokens.ready;

	assign cnt_m2    = count_q - CNT_W'(2);
	assign cnt_p1    = count_q + CNT_W'(1);
	assign full      = count_q >= CNT_W'(STACK_DEPTH);
	assign two_up    = count_q >= CNT_W'(2);
	assign num_fx    = sat_word(64'(tokens.number_value) <<< FRAC_BITS);
	assign top_shown = (count_q == '0) ? '0 : top_q;

	// Operators: a is second from top (memory), b is the top (register)
	assign add_res = sat_word(64'(rd_q) + 64'(top_q));
	assign sub_res = sat_word(64'(rd_q) - 64'(top_q));
	assign mul_res = sat_word(prod_q >>> FRAC_BITS);

	assign abs_a = rd_q[DATA_W-1] ? DATA_W'(-rd_q) : rd_q;
	assign abs_b = top_q[DATA_W-1] ? DATA_W'(-top_q) : top_q;
	assign div_start = (state_q == S_READ) && (func_q == FN_DIV) && (top_q != '0);

	rpn_calc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DV_W'(abs_a) << FRAC_BITS),
		.divisor  (abs_b),
		.neg      (rd_q[DATA_W-1] ^ top_q[DATA_W-1]),
		.done     (div_done),
		.quot     (div_quot)
	);

	// Memory port control: push a number, read an operand, write back a result
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[ADDR_W-1:0];
		mem_wdata = num_fx;
		mem_re    = 1'b0;
		if (accept && tokens.func == FN_NUM && !full)
			mem_we = 1'b1;
		if (state_q == S_WB) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_m2[ADDR_W-1:0];
			mem_wdata = res_val_q;
		end
		if (accept && two_up &&
		    (tokens.func == FN_ADD || tokens.func == FN_SUB ||
		     tokens.func == FN_MUL || tokens.func == FN_DIV))
			mem_re = 1'b1;
	end

	// Operand stack storage
	always_ff @(posedge clk) begin
		if (mem_we)
			stack_mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= stack_mem[cnt_m2[ADDR_W-1:0]];
	end

	// Token sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			// Load the result register when it is free or draining, else drop valid on ready
			if (state_q == S_EMIT && (!out_valid_q || results.ready))
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q     <= tokens.func;
						res_done_q <= (tokens.func == FN_FIN);
						state_q    <= mem_re ? S_READ : S_EMIT;
						case (tokens.func)
							FN_NUM: begin
								if (!full) begin
									count_q      <= cnt_p1;
									top_q        <= num_fx;
									res_top_q    <= num_fx;
									res_status_q <= err_q;
								end else begin
									err_q        <= flag_err(err_q, ST_OVER);
									res_top_q    <= top_shown;
									res_status_q <= flag_err(err_q, ST_OVER);
								end
							end
							FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
								if (!two_up) begin
									err_q        <= flag_err(err_q, ST_UNDER);
									res_top_q    <= top_shown;
									res_status_q <= flag_err(err_q, ST_UNDER);
								end
							end
							FN_FIN: begin
								if (count_q == '0) begin
									res_top_q    <= '0;
									res_status_q <= flag_err(err_q, ST_UNDER);
								end else begin
									res_top_q    <= top_q;
									res_status_q <= (count_q > CNT_W'(1)) ?
									                flag_err(err_q, ST_LEFT) : err_q;
								end
								count_q <= '0;
								err_q   <= ST_OK;
							end
							default: begin
								res_top_q    <= top_shown;
								res_status_q <= err_q;
							end
						endcase
					end
				end
				S_READ: begin
					case (func_q)
						FN_ADD: begin
							res_val_q <= add_res;
							state_q   <= S_WB;
						end
						FN_SUB: begin
							res_val_q <= sub_res;
							state_q   <= S_WB;
						end
						FN_MUL: begin
							prod_q  <= 64'(rd_q) * 64'(top_q);
							state_q <= S_MUL;
						end
						FN_DIV: begin
							if (top_q == '0) begin
								err_q   <= flag_err(err_q, ST_DIV0);
								state_q <= S_WB;
								if (rd_q == '0)
									res_val_q <= '0;
								else if (rd_q[DATA_W-1])
									res_val_q <= WORD_MIN;
								else
									res_val_q <= WORD_MAX;
							end else begin
								state_q <= S_DIV;
							end
						end
						default: begin
							res_val_q <= top_q;
							state_q   <= S_WB;
						end
					endcase
				end
				S_MUL: begin
					res_val_q <= mul_res;
					state_q   <= S_WB;
				end
				S_DIV: begin
					if (div_done) begin
						res_val_q <= div_quot;
						state_q   <= S_WB;
					end
				end
				S_WB: begin
					// Pop two, push one
					count_q      <= count_q - CNT_W'(1);
					top_q        <= res_val_q;
					res_top_q    <= res_val_q;
					res_status_q <= err_q;
					res_done_q   <= 1'b0;
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || results.ready) begin
						out_top_q    <= res_top_q;
						out_status_q <= res_status_q;
						out_done_q   <= res_done_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign results.valid           = out_valid_q;
	assign results.top_value       = out_top_q;
	assign results.status          = out_status_q;
	assign results.expression_done = out_done_q;

	// Stack count stays within the memory
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// Write-back only happens with two operands popped
	a_wb_two: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WB |-> count_q >= CNT_W'(2))
		else $error("write-back with fewer than two operands");

	// A finished expression leaves an empty stack and clean status
	a_fin_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && res_done_q) |-> (count_q == '0 && err_q == ST_OK))
		else $error("finish did not clear the stack");

	// Divider reports only while a divide waits on it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider done outside a divide");

endmodule

// ===== bench/rpn_result_checker.sv =====
// Watches both channels, tracks the operand stack and checks every result word
module rpn_result_checker import rpn_calc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rpn_in_if    tokens,
	rpn_out_if   results,
	output int   fails,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		word_t   top_value;
		status_t status;
		logic    done;
	} outcome_t;

	outcome_t outcome_q[$];
	word_t    stack_copy[STACK_DEPTH];
	int       stack_fill;
	status_t  sticky_err;
	int       mismatch_count = 0;
	int       waiting_n = 0;

	assign fails   = mismatch_count;
	assign pending = waiting_n;

	// Clamp a wide signed value to the 32-bit word range
	function automatic word_t clamp_word(longint v);
		word_t r;
		if (v > longint'(WORD_MAX))
			r = WORD_MAX;
		else if (v < longint'(WORD_MIN))
			r = WORD_MIN;
		else
			r = word_t'(v);
		return r;
	endfunction

	// Keep only the first error since the last finish
	function automatic void note_error(status_t s);
		if (sticky_err == ST_OK)
			sticky_err = s;
	endfunction

	function automatic void push_word(word_t w);
		if (stack_fill >= STACK_DEPTH) begin
			note_error(ST_OVER);
		end else begin
			stack_copy[stack_fill] = w;
			stack_fill++;
		end
	endfunction

	function automatic word_t top_word();
		word_t r;
		r = '0;
		if (stack_fill > 0)
			r = stack_copy[stack_fill-1];
		return r;
	endfunction

	// Work out a op b in Q16.16 with saturation
	function automatic word_t combine(func_t f, word_t a, word_t b);
		longint wide;
		word_t  r;
		r = '0;
		case (f)
			FN_ADD: r = clamp_word(longint'(a) + longint'(b));
			FN_SUB: r = clamp_word(longint'(a) - longint'(b));
			FN_MUL: begin
				// arithmetic shift rounds toward minus infinity
				wide = longint'(a) * longint'(b);
				r = clamp_word(wide >>> FRAC_BITS);
			end
			default: begin
				if (b == 0) begin
					note_error(ST_DIV0);
					if (a > 0)
						r = WORD_MAX;
					else if (a < 0)
						r = WORD_MIN;
					else
						r = '0;
				end else begin
					wide = (longint'(a) <<< FRAC_BITS) / longint'(b);
					r = clamp_word(wide);
				end
			end
		endcase
		return r;
	endfunction

	// Advance the stack copy by one token and return the result word it should give
	function automatic outcome_t eval_token(func_t f, logic signed [NUM_W-1:0] v);
		outcome_t o;
		word_t    a;
		word_t    b;
		o.done = 1'b0;
		if (f == FN_NUM) begin
			push_word(word_t'(longint'(v) <<< FRAC_BITS));
			o.top_value = top_word();
			o.status    = sticky_err;
		end else if (f == FN_ADD || f == FN_SUB || f == FN_MUL || f == FN_DIV) begin
			if (stack_fill < 2) begin
				note_error(ST_UNDER);
			end else begin
				b = stack_copy[stack_fill-1];
				a = stack_copy[stack_fill-2];
				stack_fill -= 2;
				push_word(combine(f, a, b));
			end
			o.top_value = top_word();
			o.status    = sticky_err;
		end else if (f == FN_FIN) begin
			if (stack_fill == 0) begin
				note_error(ST_UNDER);
				o.top_value = '0;
			end else begin
				o.top_value = top_word();
				if (stack_fill > 1)
					note_error(ST_LEFT);
			end
			o.status   = sticky_err;
			o.done     = 1'b1;
			stack_fill = 0;
			sticky_err = ST_OK;
		end else begin
			// spare codes leave the stack alone
			o.top_value = top_word();
			o.status    = sticky_err;
		end
		return o;
	endfunction

	task automatic report(string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Check the result word first, then predict from the token word
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			stack_fill = 0;
			sticky_err = ST_OK;
			outcome_q.delete();
			waiting_n <= 0;
		end else begin
			if (results.valid && results.ready) begin
				if (outcome_q.size() == 0) begin
					report($sformatf("result word with nothing expected: top %0d status %0d",
						results.top_value, results.status));
				end else begin
					want = outcome_q.pop_front();
					if (results.top_value !== want.top_value)
						report($sformatf("top_value got %0d want %0d",
							results.top_value, want.top_value));
					if (results.status !== want.status)
						report($sformatf("status got %0d want %0d",
							results.status, want.status));
					if (results.expression_done !== want.done)
						report($sformatf("expression_done got %b want %b",
							results.expression_done, want.done));
				end
			end
			if (tokens.valid && tokens.ready)
				outcome_q.push_back(eval_token(tokens.func, tokens.number_value));
			waiting_n <= outcome_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
module tb_top import rpn_calc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam func_t FN_SPARE6   = 3'd6;
	localparam func_t FN_SPARE7   = 3'd7;
	localparam int    TOKEN_GOAL  = 650;
	localparam int    CALM_FROM   = 530;
	localparam int    DRAIN_AT    = 300;
	localparam int    IDLE_LIMIT  = 3000;
	localparam int    TAIL_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	bit   drained;
	int   stall_left;
	int   tokens_sent;
	int   idle_cycles;
	int   fail_cnt;
	int   pend_cnt;

	rpn_in_if  tok_ch ();
	rpn_out_if res_ch ();

	rpn_stack_calculator_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.tokens  (tok_ch),
		.results (res_ch)
	);

	rpn_result_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.tokens  (tok_ch),
		.results (res_ch),
		.fails   (fail_cnt),
		.pending (pend_cnt)
	);

	always #1 clk = ~clk;

	// Stall the result channel in short bursts, never once the run turns calm
	always @(negedge clk) begin
		logic nxt;
		if (calm) begin
			nxt = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			nxt = 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 6);
			nxt = 1'b0;
		end else begin
			nxt = 1'b1;
		end
		res_ch.ready <= nxt;
	end

	// End the run when no word moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tok_ch.valid && tok_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("rpn_stack_calculator_unit test failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Offer one token word, sometimes after a random gap, and hold it until taken
	task automatic send_token(func_t f, logic signed [NUM_W-1:0] v);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 7);
		@(negedge clk);
		if (gap > 0) begin
			tok_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tok_ch.valid        <= 1'b1;
		tok_ch.func         <= f;
		tok_ch.number_value <= v;
		do @(posedge clk); while (!tok_ch.ready);
		if (f <= FN_FIN)
			tokens_sent++;
	endtask

	task automatic push_num(int v);
		send_token(FN_NUM, NUM_W'(v));
	endtask

	// Drop valid and hold until every result word has come back
	task automatic hold_until_drained();
		@(negedge clk);
		tok_ch.valid <= 1'b0;
		do @(posedge clk); while (pend_cnt != 0);
	endtask

	function automatic logic signed [NUM_W-1:0] rand_number();
		logic signed [NUM_W-1:0] r;
		int k;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				k = $urandom_range(0, 8);
				k = k - 4;
				r = NUM_W'(k);
			end
			4: begin
				case ($urandom_range(0, 4))
					0: r = 16'sh7fff;
					1: r = 16'sh8000;
					2: r = 16'sh0000;
					3: r = 16'sh0001;
					default: r = 16'shffff;
				endcase
			end
			default: r = NUM_W'($urandom());
		endcase
		return r;
	endfunction

	// One expression: mostly well formed, with some stray and spare tokens
	task automatic random_expression(bit deep);
		int depth;
		int steps;
		int i;
		depth = 0;
		if (deep) begin
			steps = $urandom_range(14, 18);
			for (i = 0; i < steps; i++) begin
				send_token(FN_NUM, rand_number());
				if (depth < STACK_DEPTH)
					depth++;
			end
		end
		steps = $urandom_range(1, 12);
		for (i = 0; i < steps; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				send_token(func_t'($urandom_range(0, 7)), rand_number());
			end else if (depth < 2 || (depth < STACK_DEPTH && $urandom_range(0, 2) == 0)) begin
				send_token(FN_NUM, rand_number());
				depth++;
			end else begin
				send_token(func_t'($urandom_range(FN_ADD, FN_DIV)), rand_number());
				depth--;
			end
		end
		// fold what is left, sometimes leaving operands behind
		while (depth > 1 && $urandom_range(0, 7) != 0) begin
			send_token(func_t'($urandom_range(FN_ADD, FN_DIV)), rand_number());
			depth--;
		end
		send_token(FN_FIN, rand_number());
	endtask

	initial begin
		arst_n              = 1'b0;
		calm                = 1'b0;
		drained             = 1'b0;
		tokens_sent         = 0;
		tok_ch.valid        = 1'b0;
		tok_ch.func         = FN_NUM;
		tok_ch.number_value = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// finish on an empty stack, operators short of operands
		send_token(FN_FIN, '0);
		send_token(FN_ADD, '0);
		push_num(5);
		send_token(FN_SUB, '0);
		send_token(FN_FIN, '0);
		// saturating add and sub at the number extremes
		push_num(32767);
		push_num(32767);
		send_token(FN_ADD, '0);
		push_num(-32768);
		push_num(1);
		send_token(FN_SUB, '0);
		// truncating divide, then a product that saturates
		push_num(-7);
		push_num(3);
		send_token(FN_DIV, '0);
		send_token(FN_MUL, '0);
		// divide by zero with positive, zero and negative dividends
		push_num(0);
		send_token(FN_DIV, '0);
		push_num(0);
		push_num(0);
		send_token(FN_DIV, '0);
		push_num(-1);
		push_num(0);
		send_token(FN_DIV, '0);
		send_token(FN_SPARE6, 16'sh5a5a);
		send_token(FN_SPARE7, 16'sha5a5);
		// leftover operands; the divide by zero stays the reported error
		send_token(FN_FIN, '0);
		// product of a negative and a positive fraction rounds toward minus infinity
		push_num(-1);
		push_num(3);
		send_token(FN_DIV, '0);
		push_num(1);
		push_num(3);
		send_token(FN_DIV, '0);
		send_token(FN_MUL, '0);
		send_token(FN_FIN, '0);

		// random expressions; fill past the stack now and then
		while (tokens_sent < TOKEN_GOAL) begin
			if (tokens_sent >= CALM_FROM)
				calm = 1'b1;
			if (tokens_sent >= DRAIN_AT && !drained) begin
				hold_until_drained();
				drained = 1'b1;
			end
			random_expression($urandom_range(0, 11) == 0);
		end

		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && pend_cnt == 0)
			$display("rpn_stack_calculator_unit test passed");
		else
			$display("rpn_stack_calculator_unit test failed");
		$finish;
	end

endmodule
